// ===== design/pbrt_pkg.sv =====
// shared types and constants for the piece block request tracker
// no dependencies
package pbrt_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_SCAN  = 2'd1,
    CMD_SWEEP = 2'd2,
    CMD_RECV  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_REQUEST = 3'd0,
    KIND_RXSTAT  = 3'd1,
    KIND_SWEEP   = 3'd2,
    KIND_START   = 3'd3,
    KIND_NONE    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_IDLE     = 3'd1,
    ST_BADIDX   = 3'd2,
    ST_WRONG    = 3'd3,
    ST_MISALIGN = 3'd4,
    ST_BEYOND   = 3'd5,
    ST_SIZE     = 3'd6,
    ST_DUP      = 3'd7
  } rx_status_e;

  typedef enum logic [2:0] {
    REG_PIECE_BYTES = 3'd0,
    REG_PIECE_NUM   = 3'd1,
    REG_PIECE_TOTAL = 3'd2,
    REG_MAX_OUT     = 3'd3,
    REG_TIMEOUT     = 3'd4
  } reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_CLEAR,
    BK_DONE
  } bk_state_e;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 21;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  now_secs;
    logic [31:0] rx_piece_index;
    logic [31:0] rx_begin;
    logic [31:0] rx_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [19:0] req_piece;
    logic [19:0] req_offset;
    logic [14:0] req_bytes;
    logic [2:0]  rx_status;
    logic        piece_complete;
    logic [6:0]  cleared_count;
    logic [4:0]  in_flight;
    logic        last_of_run;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  now;
    logic        idx_bad;
    logic        piece_wrong;
    logic        misaligned;
    logic        blk_hi_zero;
    logic [31:0] rx_length;
    logic [31:0] rx_begin;
  } job_t;

endpackage

// ===== design/piece_block_request_tracker.sv =====
// top level of the piece block request tracker: config registers, front and back
// depends on pbrt_pkg, pbrt_front, pbrt_back
//
// Start clears the time table one entry per cycle, scan and sweep walk the time
// table one block per cycle, and receive is handled in the done state; the last
// request of a scan leaves from the hold stage after the scan ends. Two commands
// can queue behind the one in work; busy is high while the queue is full. Results
// appear for one cycle with res_valid_o and cannot be stalled; the last result of
// a command has last_of_run set.
module piece_block_request_tracker
  import pbrt_pkg::*;
#(
  parameter int unsigned MaxBlocks  = 64,
  parameter int unsigned BlockBytes = 16384
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              item_i,
  output logic                  res_valid_o,
  output out_item_t             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);
  logic [20:0] piece_bytes_q;
  logic [19:0] piece_num_q;
  logic [20:0] piece_total_q;
  logic [4:0]  max_out_q;
  logic [7:0]  timeout_q;
  logic        job_valid, job_pop;
  job_t        job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piece_bytes_q <= 21'd262144;
      piece_num_q   <= '0;
      piece_total_q <= 21'd1;
      max_out_q     <= 5'd10;
      timeout_q     <= 8'd4;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_PIECE_BYTES: piece_bytes_q <= cfg_data_i;
        REG_PIECE_NUM:   piece_num_q   <= cfg_data_i[19:0];
        REG_PIECE_TOTAL: piece_total_q <= cfg_data_i;
        REG_MAX_OUT:     max_out_q     <= cfg_data_i[4:0];
        REG_TIMEOUT:     timeout_q     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  pbrt_front #(.BlockBytes(BlockBytes), .MaxBlocks(MaxBlocks)) u_front (
    .clk_i, .rst_ni,
    .start_i(start), .busy_o(busy), .item_i,
    .piece_num_i(piece_num_q), .piece_total_i(piece_total_q),
    .job_valid_o(job_valid), .job_o(job), .job_pop_i(job_pop)
  );

  pbrt_back #(.BlockBytes(BlockBytes), .MaxBlocks(MaxBlocks)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_i(job), .job_pop_o(job_pop),
    .piece_bytes_i(piece_bytes_q), .piece_num_i(piece_num_q),
    .max_out_i(max_out_q), .timeout_i(timeout_q),
    .res_valid_o, .res_o
  );
endmodule

// ===== design/pbrt_front.sv =====
// front part: classifies accepted items and queues them for the back part
// depends on pbrt_pkg
module pbrt_front
  import pbrt_pkg::*;
#(
  parameter int unsigned BlockBytes = 16384,
  parameter int unsigned MaxBlocks  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  in_item_t    item_i,
  input  logic [19:0] piece_num_i,
  input  logic [20:0] piece_total_i,
  output logic        job_valid_o,
  output job_t        job_o,
  input  logic        job_pop_i
);
  localparam int unsigned BShift = $clog2(BlockBytes);
  localparam int unsigned BlkW   = $clog2(MaxBlocks) + 1;

  // two-entry queue
  job_t       q_mem [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       push;
  job_t       j;

  assign busy_o = cnt_q[1];
  assign push   = start_i && !busy_o;

  always_comb begin
    j             = '0;
    j.cmd         = item_i.cmd;
    j.now         = (item_i.now_secs == 8'd0) ? 8'd1 : item_i.now_secs;
    j.idx_bad     = item_i.rx_piece_index >= {11'd0, piece_total_i};
    j.piece_wrong = item_i.rx_piece_index != {12'd0, piece_num_i};
    j.misaligned  = item_i.rx_begin[BShift-1:0] != '0;
    j.blk_hi_zero = item_i.rx_begin[31:BShift+BlkW-1] == '0;
    j.rx_length   = item_i.rx_length;
    j.rx_begin    = item_i.rx_begin;
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= j;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !job_pop_i) cnt_d = cnt_q + 2'd1;
    else if (!push && job_pop_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wp_q <= ~wp_q;
      if (job_pop_i) rp_q <= ~rp_q;
    end
  end

  assign job_valid_o = cnt_q != 2'd0;
  assign job_o       = q_mem[rp_q];

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_i |-> job_valid_o) else $error("pop from empty queue");
  a_full_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> busy_o) else $error("full queue not busy");
endmodule

// ===== design/pbrt_back.sv =====
// back part: walks the block tables for start, scan and sweep, handles receives
// depends on pbrt_pkg
module pbrt_back
  import pbrt_pkg::*;
#(
  parameter int unsigned BlockBytes = 16384,
  parameter int unsigned MaxBlocks  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  input  logic [20:0] piece_bytes_i,
  input  logic [19:0] piece_num_i,
  input  logic [4:0]  max_out_i,
  input  logic [7:0]  timeout_i,
  output logic        res_valid_o,
  output out_item_t   res_o
);
  localparam int unsigned BShift = $clog2(BlockBytes);
  localparam int unsigned IdxW   = (MaxBlocks > 1) ? $clog2(MaxBlocks) : 1;
  localparam int unsigned BlkW   = $clog2(MaxBlocks) + 1;
  localparam int unsigned LenW   = BShift + BlkW + 1;
  localparam int unsigned TailW  = BShift + 1;

  logic [7:0]      asked_q [MaxBlocks];
  logic [MaxBlocks-1:0] got_q;
  logic [BlkW-1:0] recv_q, total_q;
  logic [4:0]      out_q;
  logic [TailW-1:0] tail_q;
  logic            dl_q;

  bk_state_e       st_q, st_d;
  job_t            job_q;
  logic [BlkW-1:0] i_q;
  logic [4:0]      n_q;
  logic [6:0]      clr_q;
  logic            res_v_q;
  out_item_t       res_q;
  logic [7:0]      a_q;

  logic [LenW-1:0] len, cap, lenm1;
  logic [BlkW-1:0] new_total;
  logic [IdxW-1:0] ix, rd_ix;
  logic [7:0]      a;
  logic            g, walk_end, limit_hit, adv;
  logic [4:0]      limit;
  logic [8:0]      age_sum;
  logic            is_last;
  logic [BlkW-1:0] blk;
  logic [2:0]      rx_st;

  assign ix = i_q[IdxW-1:0];
  // time table is read ahead of the walk through the a_q register
  assign a  = a_q;
  assign g  = got_q[ix];
  assign limit = (max_out_i > 5'd16) ? 5'd16 : max_out_i;
  assign walk_end = (i_q >= total_q);
  assign limit_hit = (out_q >= limit) || (n_q >= 5'd16);
  assign age_sum = {1'b0, a} + {1'b0, timeout_i};
  assign is_last = (i_q == total_q - 1'b1);
  assign blk = job_q.rx_begin[BShift+BlkW-1:BShift];
  assign adv = (st_q == BK_WALK) && dl_q && !walk_end &&
               (job_q.cmd != CMD_SCAN || !limit_hit);

  always_comb begin
    if (st_q == BK_IDLE) rd_ix = '0;
    else if (adv) rd_ix = IdxW'(ix + 1'b1);
    else rd_ix = ix;
  end

  always_comb begin
    cap = LenW'(MaxBlocks * BlockBytes);
    len = {{(LenW-21){1'b0}}, piece_bytes_i};
    if (piece_bytes_i == 21'd0) len = LenW'(1);
    if (len > cap) len = cap;
    lenm1 = len - 1'b1;
    new_total = BlkW'(lenm1 >> BShift) + 1'b1;
  end

  always_comb begin
    if (job_q.idx_bad) rx_st = ST_BADIDX;
    else if (!dl_q) rx_st = ST_IDLE;
    else if (job_q.piece_wrong) rx_st = ST_WRONG;
    else if (job_q.misaligned) rx_st = ST_MISALIGN;
    else if (!job_q.blk_hi_zero || blk >= total_q) rx_st = ST_BEYOND;
    else if (blk == total_q - 1'b1 &&
             job_q.rx_length != {{(32-TailW){1'b0}}, tail_q}) rx_st = ST_SIZE;
    else if (blk != total_q - 1'b1 && job_q.rx_length != 32'(BlockBytes)) rx_st = ST_SIZE;
    else if (got_q[blk[IdxW-1:0]]) rx_st = ST_DUP;
    else rx_st = ST_OK;
  end

  assign job_pop_o = (st_q == BK_IDLE) && job_valid_i;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          unique case (cmd_e'(job_i.cmd))
            CMD_START: st_d = BK_CLEAR;
            CMD_SCAN, CMD_SWEEP: st_d = BK_WALK;
            CMD_RECV: st_d = BK_DONE;
            default: st_d = BK_IDLE;
          endcase
        end
      end
      BK_CLEAR: if (i_q == BlkW'(MaxBlocks - 1)) st_d = BK_DONE;
      BK_WALK: begin
        if (!dl_q || walk_end || (job_q.cmd == CMD_SCAN && limit_hit)) st_d = BK_DONE;
      end
      BK_DONE: st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BK_CLEAR) asked_q[ix] <= 8'd0;
    else if (st_q == BK_WALK && dl_q && !walk_end) begin
      if (job_q.cmd == CMD_SCAN && !limit_hit && a == 8'd0 && !g) asked_q[ix] <= job_q.now;
      else if (job_q.cmd == CMD_SWEEP && a != 8'd0 && !g && age_sum < {1'b0, job_q.now})
        asked_q[ix] <= 8'd0;
    end
    a_q <= asked_q[rd_ix];
    if (job_pop_o) job_q <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= BK_IDLE;
      got_q   <= '0;
      recv_q  <= '0;
      total_q <= '0;
      out_q   <= '0;
      tail_q  <= TailW'(BlockBytes);
      dl_q    <= 1'b0;
      i_q     <= '0;
      n_q     <= '0;
      clr_q   <= '0;
      res_v_q <= 1'b0;
      res_q   <= '0;
    end else begin
      st_q    <= st_d;
      res_v_q <= 1'b0;
      unique case (st_q)
        BK_IDLE: begin
          i_q <= '0; n_q <= '0; clr_q <= '0;
          if (job_pop_o && job_i.cmd == CMD_START) begin
            total_q <= new_total;
            tail_q  <= TailW'(len - LenW'((new_total - 1'b1)) * LenW'(BlockBytes));
            got_q   <= '0;
            recv_q  <= '0;
            out_q   <= '0;
            dl_q    <= 1'b1;
          end
        end
        BK_CLEAR: i_q <= i_q + 1'b1;
        BK_WALK: begin
          if (dl_q && !walk_end) begin
            if (job_q.cmd == CMD_SCAN) begin
              if (!limit_hit) begin
                i_q <= i_q + 1'b1;
                if (a == 8'd0 && !g) begin
                  out_q   <= out_q + 1'b1;
                  n_q     <= n_q + 1'b1;
                  res_v_q <= 1'b1;
                  res_q   <= '0;
                  res_q.kind       <= KIND_REQUEST;
                  res_q.req_piece  <= piece_num_i;
                  res_q.req_offset <= 20'({{(20-BlkW){1'b0}}, i_q} << BShift);
                  res_q.req_bytes  <= is_last ? 15'(tail_q) : 15'(BlockBytes);
                  res_q.piece_complete <= (total_q != '0) && (recv_q == total_q);
                  res_q.in_flight  <= out_q + 1'b1;
                end
              end
            end else begin
              i_q <= i_q + 1'b1;
              if (a != 8'd0 && !g && age_sum < {1'b0, job_q.now}) begin
                clr_q <= clr_q + 1'b1;
                if (out_q != 5'd0) out_q <= out_q - 1'b1;
              end
            end
          end
        end
        BK_DONE: begin
          res_v_q <= 1'b1;
          res_q   <= '0;
          res_q.last_of_run <= 1'b1;
          res_q.in_flight   <= out_q;
          res_q.piece_complete <= (total_q != '0) && (recv_q == total_q);
          unique case (cmd_e'(job_q.cmd))
            CMD_START: res_q.kind <= KIND_START;
            CMD_SWEEP: begin
              res_q.kind <= KIND_SWEEP;
              res_q.cleared_count <= clr_q;
            end
            CMD_SCAN: begin
              // last request carries the end mark; none issued gives its own result
              if (n_q != 5'd0) begin
                res_q <= res_q;
                res_q.last_of_run <= 1'b1;
                res_v_q <= 1'b0;
              end else res_q.kind <= KIND_NONE;
            end
            CMD_RECV: begin
              res_q.kind <= KIND_RXSTAT;
              res_q.rx_status <= rx_st;
              if (rx_st == ST_OK) begin
                got_q[blk[IdxW-1:0]] <= 1'b1;
                recv_q <= recv_q + 1'b1;
                if (out_q != 5'd0) out_q <= out_q - 1'b1;
                res_q.in_flight <= (out_q != 5'd0) ? out_q - 1'b1 : 5'd0;
                res_q.piece_complete <= (recv_q + 1'b1 == total_q);
                if (recv_q + 1'b1 == total_q) dl_q <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // requests are held back in a register so the final one can carry the end mark
  out_item_t hold_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q   <= '0;
    end else begin
      if (res_v_q) hold_q <= res_q;
      else if (st_q == BK_DONE && job_q.cmd == CMD_SCAN && n_q != 5'd0)
        hold_q.last_of_run <= 1'b1;
    end
  end

  // non-request results pass straight; requests leave from the hold stage
  logic      pend_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= 1'b0;
    else if (res_v_q && res_q.kind == KIND_REQUEST) pend_q <= 1'b1;
    else if (pend_q && (res_v_q || st_q == BK_IDLE)) pend_q <= pend_q && res_v_q;
  end

  assign res_valid_o = (res_v_q && res_q.kind != KIND_REQUEST) ||
                       (pend_q && (res_v_q || (st_q == BK_IDLE)));
  assign res_o = (res_v_q && res_q.kind != KIND_REQUEST) ? res_q : hold_q;

  a_out_cap: assert property (@(posedge clk_i) disable iff (!rst_ni) out_q <= 5'd16)
    else $error("outstanding above limit");
  a_recv_cap: assert property (@(posedge clk_i) disable iff (!rst_ni) recv_q <= total_q)
    else $error("received above total");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> st_q != BK_IDLE) else $error("pop without work");
endmodule
